// ===== rtl/core/ngr_pkg.sv =====
`default_nettype none
package ngr_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_PASSES_DEF  = 26;
  localparam int NORM_SWAPS_DEF  = 5;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int DELTA_W  = 31;
  localparam int FIELD_W  = 32;
  localparam int TRANS_W  = 16;
  localparam int STATUS_W = 2;
  localparam int ROW_W    = 3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NEG = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVF = 2'd2;

  // Control between front and back
  typedef struct packed {
    logic valid;
    logic bad;
  } ngr_qctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/niggli_g6_reducer.sv =====
// Channel | Direction | Payload
// in_     | input     | g1..g6, signed Q15.16 G6 vector
// out_    | output    | row, reduced_value, m_col0..m_col5, status, last (six per item)
// cfg_    | input     | delta, Q15.16 tolerance, written when cfg_wr_en is high
//
// A two-entry queue takes items while the engine works on an earlier one.
// Each matrix step evaluates, applies six row products and commits; a pass
// has up to 2*NORM_SWAPS+3 steps plus the phase decisions, and after the load
// an item takes up to MAX_PASSES passes through the shared row-product datapath.
// Six result rows follow (directly after the load for an out-of-range input);
// out_ready low holds the current row.
// rst_n is synchronous and active low; it empties the queue and idles the engine.
`default_nettype none
module niggli_g6_reducer #(
  parameter int MAX_PASSES  = ngr_pkg::MAX_PASSES_DEF,
  parameter int NORM_SWAPS  = ngr_pkg::NORM_SWAPS_DEF,
  parameter int VALUE_WIDTH = ngr_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [ngr_pkg::DELTA_W-1:0]         cfg_wr_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [ngr_pkg::FIELD_W-1:0]  in_g1,
  input  wire logic signed [ngr_pkg::FIELD_W-1:0]  in_g2,
  input  wire logic signed [ngr_pkg::FIELD_W-1:0]  in_g3,
  input  wire logic signed [ngr_pkg::FIELD_W-1:0]  in_g4,
  input  wire logic signed [ngr_pkg::FIELD_W-1:0]  in_g5,
  input  wire logic signed [ngr_pkg::FIELD_W-1:0]  in_g6,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [ngr_pkg::ROW_W-1:0]                out_row,
  output logic signed [ngr_pkg::FIELD_W-1:0]       out_reduced_value,
  output logic signed [ngr_pkg::TRANS_W-1:0]       out_m_col0,
  output logic signed [ngr_pkg::TRANS_W-1:0]       out_m_col1,
  output logic signed [ngr_pkg::TRANS_W-1:0]       out_m_col2,
  output logic signed [ngr_pkg::TRANS_W-1:0]       out_m_col3,
  output logic signed [ngr_pkg::TRANS_W-1:0]       out_m_col4,
  output logic signed [ngr_pkg::TRANS_W-1:0]       out_m_col5,
  output logic [ngr_pkg::STATUS_W-1:0]             out_status,
  output logic                                     out_last
);
  import ngr_pkg::*;

  localparam int SW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

  logic [DELTA_W-1:0]      delta_r;
  logic signed [FIELD_W-1:0] g [6];
  logic signed [TRANS_W-1:0] m [6];
  ngr_qctl_t               q_ctl;
  logic [6*SW-1:0]         q_vec;
  logic                    q_ready;

  // Hold the tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) delta_r <= '0;
    else if (cfg_wr_en) delta_r <= cfg_wr_data;
  end

  assign g[0] = in_g1;
  assign g[1] = in_g2;
  assign g[2] = in_g3;
  assign g[3] = in_g4;
  assign g[4] = in_g5;
  assign g[5] = in_g6;

  ngr_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_g(g), .q_ctl, .q_vec, .q_ready
  );

  ngr_back #(
    .MAX_PASSES(MAX_PASSES), .NORM_SWAPS(NORM_SWAPS), .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk, .rst_n, .delta(delta_r), .q_ctl, .q_vec, .q_ready,
    .out_valid, .out_ready, .out_row, .out_reduced_value, .out_m(m),
    .out_status, .out_last
  );

  assign out_m_col0 = m[0];
  assign out_m_col1 = m[1];
  assign out_m_col2 = m[2];
  assign out_m_col3 = m[3];
  assign out_m_col4 = m[4];
  assign out_m_col5 = m[5];

endmodule
`default_nettype wire

// ===== rtl/core/ngr_front.sv =====
`default_nettype none
module ngr_front #(
  parameter int VALUE_WIDTH = ngr_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [ngr_pkg::FIELD_W-1:0] in_g [6],
  output ngr_pkg::ngr_qctl_t                     q_ctl,
  output logic [6*((VALUE_WIDTH > 32) ? VALUE_WIDTH : 32)-1:0] q_vec,
  input  wire logic                              q_ready
);
  import ngr_pkg::*;

  localparam int SW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
  localparam int XW = SW + 1;
  localparam logic signed [XW-1:0] VMAX_X = XW'((65'sd1 <<< (VALUE_WIDTH - 1)) - 65'sd1);
  localparam logic signed [XW-1:0] VMIN_X = -VMAX_X - XW'(1);

  logic [6*SW-1:0] word_nxt;
  logic            bad_nxt;
  logic [6*SW-1:0] mem_r [2];
  logic            bad_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;
  logic            push, pop;
  logic signed [XW-1:0] ext [6];

  // Classify: range check each component against the working width
  always_comb begin
    bad_nxt = 1'b0;
    for (int i = 0; i < 6; i++) begin
      ext[i] = XW'(in_g[i]);
      if (ext[i] > VMAX_X || ext[i] < VMIN_X) bad_nxt = 1'b1;
      word_nxt[i*SW +: SW] = ext[i][SW-1:0];
    end
  end

  assign in_ready    = (cnt_r != 2'd2);
  assign push        = in_valid && in_ready;
  assign q_ctl.valid = (cnt_r != 2'd0);
  assign q_ctl.bad   = bad_r[rp_r];
  assign q_vec       = mem_r[rp_r];
  assign pop         = q_ctl.valid && q_ready;

  // Hold queued transactions
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= word_nxt;
      bad_r[wp_r] <= bad_nxt;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ngr_back.sv =====
`default_nettype none
module ngr_back #(
  parameter int MAX_PASSES  = ngr_pkg::MAX_PASSES_DEF,
  parameter int NORM_SWAPS  = ngr_pkg::NORM_SWAPS_DEF,
  parameter int VALUE_WIDTH = ngr_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [ngr_pkg::DELTA_W-1:0]        delta,
  input  wire ngr_pkg::ngr_qctl_t                 q_ctl,
  input  wire logic [6*((VALUE_WIDTH > 32) ? VALUE_WIDTH : 32)-1:0] q_vec,
  output logic                                    q_ready,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [ngr_pkg::ROW_W-1:0]               out_row,
  output logic signed [ngr_pkg::FIELD_W-1:0]      out_reduced_value,
  output logic signed [ngr_pkg::TRANS_W-1:0]      out_m [6],
  output logic [ngr_pkg::STATUS_W-1:0]            out_status,
  output logic                                    out_last
);
  import ngr_pkg::*;

  localparam int SW  = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
  localparam int EW  = SW + 5;
  localparam int TSW = TRANS_W + 4;
  localparam int PW  = $clog2(MAX_PASSES + 1);
  localparam int NW  = $clog2(NORM_SWAPS + 1);
  localparam logic signed [EW-1:0] VMAX_E = EW'((65'sd1 <<< (VALUE_WIDTH - 1)) - 65'sd1);
  localparam logic signed [EW-1:0] VMIN_E = -VMAX_E - EW'(1);
  localparam logic signed [TSW-1:0] TMAX = TSW'(32767);
  localparam logic signed [TSW-1:0] TMIN = -TSW'(32768);

  localparam logic [2:0] S_IDLE = 3'd0, S_EVAL = 3'd1, S_APPLY = 3'd2,
                         S_COMMIT = 3'd3, S_OUT = 3'd4;
  localparam logic [2:0] PH_N1 = 3'd0, PH_S1 = 3'd1, PH_RULE = 3'd2,
                         PH_N2 = 3'd3, PH_S2 = 3'd4, PH_CHK = 3'd5;

  typedef logic signed [2:0] coef_t;

  logic [2:0]   st_r, ph_r;
  logic [2:0]   row_r;
  logic [PW-1:0] pass_r;
  logic [NW-1:0] norm_r;
  logic          again_r, ovf_r;
  logic [STATUS_W-1:0] status_r;
  logic signed [SW-1:0]      v_r  [6];
  logic signed [SW-1:0]      nv_r [6];
  logic signed [TRANS_W-1:0] t_r  [6][6];
  logic signed [TRANS_W-1:0] nt_r [6][6];
  coef_t m_r [6][6];
  coef_t m_nxt [6][6];
  logic  fire;

  function automatic logic signed [EW-1:0] absv(input logic signed [EW-1:0] x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic logic signed [EW-1:0] mulv(input coef_t k, input logic signed [EW-1:0] x);
    case (k)
      3'sd1:   return x;
      -3'sd1:  return -x;
      3'sd2:   return x <<< 1;
      -3'sd2:  return -(x <<< 1);
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [TSW-1:0] mult(input coef_t k, input logic signed [TSW-1:0] x);
    case (k)
      3'sd1:   return x;
      -3'sd1:  return -x;
      3'sd2:   return x <<< 1;
      -3'sd2:  return -(x <<< 1);
      default: return '0;
    endcase
  endfunction

  // Extended views of the vector and tolerance
  logic signed [EW-1:0] v [6];
  logic signed [EW-1:0] a [6];
  logic signed [EW-1:0] d, diag;
  coef_t s3, s4, s5;
  logic [2:0] pat;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      v[i] = EW'(v_r[i]);
      a[i] = absv(v[i]);
    end
    d    = EW'(signed'({1'b0, delta}));
    diag = v[3] + v[4] + v[5] + a[0] + a[1];
    s3   = (v[3] > 0) ? -3'sd1 : 3'sd1;
    s4   = (v[4] > 0) ? -3'sd1 : 3'sd1;
    s5   = (v[5] > 0) ? -3'sd1 : 3'sd1;
    pat  = {v[3] <= 0, v[4] <= 0, v[5] <= 0};
  end

  // Classify the current phase and build its step matrix
  always_comb begin
    fire = 1'b0;
    for (int r = 0; r < 6; r++)
      for (int c = 0; c < 6; c++)
        m_nxt[r][c] = (r == c) ? 3'sd1 : 3'sd0;
    case (ph_r)
      PH_N1, PH_N2: begin
        if (32'(norm_r) < NORM_SWAPS) begin
          if (a[0] > a[1] + d || (v[0] == v[1] && d == 0 && a[3] > a[4] + d)) begin
            fire = 1'b1;
            m_nxt[0][0] = 3'sd0; m_nxt[1][1] = 3'sd0; m_nxt[0][1] = 3'sd1; m_nxt[1][0] = 3'sd1;
            m_nxt[3][3] = 3'sd0; m_nxt[4][4] = 3'sd0; m_nxt[3][4] = 3'sd1; m_nxt[4][3] = 3'sd1;
          end else if (a[1] > a[2] + d ||
                       (v[1] == v[2] && d == 0 && a[4] > a[5] + d)) begin
            fire = 1'b1;
            m_nxt[1][1] = 3'sd0; m_nxt[2][2] = 3'sd0; m_nxt[1][2] = 3'sd1; m_nxt[2][1] = 3'sd1;
            m_nxt[4][4] = 3'sd0; m_nxt[5][5] = 3'sd0; m_nxt[4][5] = 3'sd1; m_nxt[5][4] = 3'sd1;
          end
        end
      end
      PH_S1, PH_S2: begin
        if (pat == 3'd1 || pat == 3'd6) begin
          fire = 1'b1; m_nxt[3][3] = -3'sd1; m_nxt[4][4] = -3'sd1;
        end else if (pat == 3'd2 || pat == 3'd5) begin
          fire = 1'b1; m_nxt[3][3] = -3'sd1; m_nxt[5][5] = -3'sd1;
        end else if (pat == 3'd3 || pat == 3'd4) begin
          fire = 1'b1; m_nxt[4][4] = -3'sd1; m_nxt[5][5] = -3'sd1;
        end
      end
      PH_RULE: begin
        fire = 1'b1;
        if (a[3] > a[1] + d) begin
          m_nxt[2][1] = 3'sd1; m_nxt[2][3] = s3; m_nxt[3][1] = s3 <<< 1; m_nxt[4][5] = s3;
        end else if (a[4] > a[0] + d) begin
          m_nxt[2][0] = 3'sd1; m_nxt[2][4] = s4; m_nxt[3][5] = s4; m_nxt[4][0] = s4 <<< 1;
        end else if (a[5] > a[0] + d) begin
          m_nxt[1][0] = 3'sd1; m_nxt[1][5] = s5; m_nxt[3][4] = s5; m_nxt[5][0] = s5 <<< 1;
        end else if (diag + d < 0) begin
          m_nxt[2][0] = 3'sd1; m_nxt[2][1] = 3'sd1; m_nxt[2][3] = 3'sd1;
          m_nxt[2][4] = 3'sd1; m_nxt[2][5] = 3'sd1;
          m_nxt[3][1] = -3'sd2; m_nxt[3][3] = -3'sd1; m_nxt[3][5] = -3'sd1;
          m_nxt[4][0] = -3'sd2; m_nxt[4][4] = -3'sd1; m_nxt[4][5] = -3'sd1;
        end else if ((absv(v[3] - v[1]) <= d && (v[4] <<< 1) - d < v[5]) ||
                     (absv(v[3] + v[1]) <= d && v[5] - d <= 0)) begin
          m_nxt[2][1] = 3'sd1; m_nxt[3][1] = 3'sd2; m_nxt[4][4] = -3'sd1;
          if (v[3] <= d) begin
            m_nxt[2][3] = 3'sd1; m_nxt[4][5] = -3'sd1; m_nxt[5][5] = -3'sd1;
          end else begin
            m_nxt[2][3] = -3'sd1; m_nxt[3][3] = -3'sd1; m_nxt[4][5] = 3'sd1;
          end
        end else if ((absv(v[4] - v[0]) <= d && (v[3] <<< 1) - d < v[5]) ||
                     (absv(v[4] + v[0]) <= d && v[5] - d <= 0)) begin
          m_nxt[2][0] = 3'sd1; m_nxt[3][3] = -3'sd1; m_nxt[4][0] = 3'sd2;
          if (v[4] <= d) begin
            m_nxt[2][4] = 3'sd1; m_nxt[3][5] = -3'sd1; m_nxt[5][5] = -3'sd1;
          end else begin
            m_nxt[2][4] = -3'sd1; m_nxt[4][4] = -3'sd1; m_nxt[3][5] = 3'sd1;
          end
        end else if ((absv(v[5] - v[0]) <= d && (v[3] <<< 1) - d < v[4]) ||
                     (absv(v[5] + v[0]) <= d && v[4] - d <= 0)) begin
          m_nxt[1][0] = 3'sd1; m_nxt[5][0] = 3'sd2; m_nxt[3][3] = -3'sd1;
          if (v[5] <= d) begin
            m_nxt[1][5] = 3'sd1; m_nxt[3][4] = -3'sd1; m_nxt[4][4] = -3'sd1;
          end else begin
            m_nxt[1][5] = -3'sd1; m_nxt[3][4] = 3'sd1; m_nxt[5][5] = -3'sd1;
          end
        end else if (absv(diag) <= d && ((a[0] + v[4]) <<< 1) + v[5] > d) begin
          m_nxt[2][0] = 3'sd1; m_nxt[2][1] = 3'sd1; m_nxt[2][3] = 3'sd1;
          m_nxt[2][4] = 3'sd1; m_nxt[2][5] = 3'sd1;
          m_nxt[3][1] = 3'sd2; m_nxt[3][5] = 3'sd1; m_nxt[4][0] = 3'sd2; m_nxt[4][5] = 3'sd1;
        end else begin
          fire = 1'b0;
        end
      end
      default: fire = 1'b0;
    endcase
  end

  // One row of the step product per cycle
  logic signed [EW-1:0]  row_v;
  logic signed [TSW-1:0] row_t [6];
  logic                  row_ovf;

  always_comb begin
    row_v   = '0;
    row_ovf = 1'b0;
    for (int c = 0; c < 6; c++) row_v = row_v + mulv(m_r[row_r][c], v[c]);
    if (row_v > VMAX_E || row_v < VMIN_E) row_ovf = 1'b1;
    for (int c = 0; c < 6; c++) begin
      row_t[c] = '0;
      for (int k = 0; k < 6; k++)
        row_t[c] = row_t[c] + mult(m_r[row_r][k], TSW'(t_r[k][c]));
      if (row_t[c] > TMAX || row_t[c] < TMIN) row_ovf = 1'b1;
    end
  end

  assign q_ready = (st_r == S_IDLE);

  // Datapath registers
  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && q_ctl.valid) begin
      for (int r = 0; r < 6; r++) begin
        v_r[r] <= q_vec[r*SW +: SW];
        for (int c = 0; c < 6; c++) t_r[r][c] <= (r == c) ? TRANS_W'(1) : '0;
      end
    end
    if (st_r == S_EVAL && fire) m_r <= m_nxt;
    if (st_r == S_APPLY) begin
      nv_r[row_r] <= row_v[SW-1:0];
      for (int c = 0; c < 6; c++) nt_r[row_r][c] <= row_t[c][TRANS_W-1:0];
    end
    if (st_r == S_COMMIT && !ovf_r) begin
      v_r <= nv_r;
      t_r <= nt_r;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      ph_r     <= PH_N1;
      row_r    <= '0;
      pass_r   <= '0;
      norm_r   <= '0;
      again_r  <= 1'b0;
      ovf_r    <= 1'b0;
      status_r <= ST_OK;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (q_ctl.valid) begin
            ph_r     <= PH_N1;
            pass_r   <= '0;
            norm_r   <= '0;
            again_r  <= 1'b1;
            row_r    <= '0;
            status_r <= q_ctl.bad ? ST_OVF : ST_OK;
            st_r     <= q_ctl.bad ? S_OUT : S_EVAL;
          end
        end
        S_EVAL: begin
          if (ph_r == PH_CHK) begin
            if (v[0] < 0 || v[1] < 0 || v[2] < 0) begin
              status_r <= ST_NEG;
              st_r     <= S_OUT;
            end else if (again_r && 32'(pass_r) + 1 < MAX_PASSES) begin
              pass_r <= pass_r + PW'(1);
              ph_r   <= PH_N1;
              norm_r <= '0;
            end else begin
              st_r <= S_OUT;
            end
          end else if (fire) begin
            if (ph_r == PH_RULE) again_r <= 1'b1;
            ovf_r <= 1'b0;
            row_r <= '0;
            st_r  <= S_APPLY;
          end else begin
            if (ph_r == PH_RULE) begin
              again_r <= 1'b0;
              norm_r  <= '0;
            end
            ph_r <= ph_r + 3'd1;
          end
        end
        S_APPLY: begin
          if (row_ovf) ovf_r <= 1'b1;
          if (row_r == 3'd5) st_r <= S_COMMIT;
          else row_r <= row_r + 3'd1;
        end
        S_COMMIT: begin
          row_r <= '0;
          if (ovf_r) begin
            status_r <= ST_OVF;
            st_r     <= S_OUT;
          end else begin
            st_r <= S_EVAL;
            if (ph_r == PH_N1 || ph_r == PH_N2) begin
              norm_r <= norm_r + NW'(1);
            end else begin
              if (ph_r == PH_RULE) norm_r <= '0;
              ph_r <= ph_r + 3'd1;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            if (row_r == 3'd5) st_r <= S_IDLE;
            else row_r <= row_r + 3'd1;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // Present the six rows of an item one at a time
  assign out_valid         = (st_r == S_OUT);
  assign out_row           = row_r;
  assign out_reduced_value = v_r[row_r][FIELD_W-1:0];
  assign out_status        = status_r;
  assign out_last          = (row_r == 3'd5);
  always_comb begin
    for (int c = 0; c < 6; c++) out_m[c] = t_r[row_r][c];
  end

endmodule
`default_nettype wire

// ===== rtl/core/ngr_checker.sv =====
`default_nettype none
module ngr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_row,
  input wire logic [1:0] out_status,
  input wire logic       out_last
);
  import ngr_pkg::*;

  // Flag only rows 0..5
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_row <= 3'd5) else $error("row out of range");

  // Last marks row 5 only
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_row == 3'd5))) else $error("last mismatch");

  // Rows advance by one within a run
  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_row == $past(out_row) + 3'd1)
    else $error("row sequence broken");

  // Status stays fixed across the rows of one run
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> !out_valid || $stable(out_status)) else $error("status changed");

  // Status is a defined code
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_NEG || out_status == ST_OVF))
    else $error("bad status code");

endmodule

bind niggli_g6_reducer ngr_checker u_ngr_checker (.*);
`default_nettype wire
